>>> rtl/gyro_drift_deadband_averager_core_macros.svh
// ----------------------------------------------------------------------------
// gyro drift deadband averager assertion macros
// clocked property checks that vanish from synthesis builds
// ----------------------------------------------------------------------------
`ifndef GYRO_DRIFT_DEADBAND_AVERAGER_CORE_MACROS_SVH
`define GYRO_DRIFT_DEADBAND_AVERAGER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define GDDA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define GDDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GDDA_ASSERT(lbl, clk, rst, prop, msg)

`define GDDA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/gdda_pkg.sv
// ----------------------------------------------------------------------------
// gdda_pkg
// widths, constants, codes and shared types of the gyro drift averager
// ----------------------------------------------------------------------------
package gdda_pkg;

  localparam int AXIS_W     = 2;
  localparam int RATE_W     = 32;
  localparam int CNT_W      = 8;
  localparam int GAIN_W     = 16;
  localparam int SUM_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_STEPS  = GAIN_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // 0.5 dps in q16.16
  localparam logic [RATE_W-1:0] HALF_DPS = 32'd32768;

  localparam logic [SUM_W-1:0] SUM_MAX = 24'h7fffff;
  localparam logic [SUM_W-1:0] SUM_MIN = 24'h800000;

  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 8'd16;
  localparam logic [GAIN_W-1:0] DRIFT_GAIN_RST   = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 1'b0,
    REG_DRIFT_GAIN   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/gdda_in_if.sv
// ----------------------------------------------------------------------------
// gdda_in_if
// sample channel: axis, current sample and previous sample of that axis
// ----------------------------------------------------------------------------
interface gdda_in_if import gdda_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [AXIS_W-1:0]        axis;
  logic signed [RATE_W-1:0] sample;
  logic signed [RATE_W-1:0] previous_sample;

  modport source (output valid, output axis, output sample, output previous_sample,
                  input ready);
  modport sink   (input valid, input axis, input sample, input previous_sample,
                  output ready);

endinterface

>>> rtl/gdda_out_if.sv
// ----------------------------------------------------------------------------
// gdda_out_if
// result channel: corrected rate, one transaction per sample
// ----------------------------------------------------------------------------
interface gdda_out_if import gdda_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] corrected_rate;

  modport source (output valid, output corrected_rate, input ready);
  modport sink   (input valid, input corrected_rate, output ready);

endinterface

>>> rtl/gdda_div.sv
// ----------------------------------------------------------------------------
// gdda_div
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// ----------------------------------------------------------------------------
`include "gyro_drift_deadband_averager_core_macros.svh"

module gdda_div import gdda_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;

  // dividend bits leave quo at the top while quotient bits enter at the bottom
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= req.divisor;
      rem <= '0;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= ge ? CNT_W'(rem_sh - {1'b0, dvs}) : rem_sh[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  assign rsp = {done, quo};

  `GDDA_ASSERT(a_rem_below_divisor, clk, rst, rsp.done |-> (rem < dvs), "remainder not below divisor")

endmodule

>>> rtl/gyro_drift_deadband_averager_core.sv
// ----------------------------------------------------------------------------
// gyro_drift_deadband_averager_core
// Deadband drift averager for gyro rates. Samples above 0.5 dps pass straight
// through and clear both run counters. A smaller sample has its magnitude
// scaled by drift_gain in a bit-serial shift-add multiplier and is compared
// with the previous magnitude; a collecting sample returns zero. When a run
// reaches sample_count, the axis sum is divided by it in a restoring divider
// that produces one quotient bit per cycle. One sample is processed at a time;
// the result register lets the next sample in while a result still waits on
// the output channel. Configuration writes are expected only while the block
// is idle.
// ----------------------------------------------------------------------------
`include "gyro_drift_deadband_averager_core_macros.svh"

module gyro_drift_deadband_averager_core import gdda_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gdda_in_if.sink               in_ch,
  gdda_out_if.source            out_ch
);

  localparam int AIDX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [3:0] AXES_L = 4'(AXES);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]  sample_count;
  logic [GAIN_W-1:0] drift_gain;
  logic [CNT_W-1:0]  rising_run;
  logic [CNT_W-1:0]  falling_run;
  logic [SUM_W-1:0]  axis_sum [AXES];

  logic [AXIS_W-1:0]        ax;
  logic signed [RATE_W-1:0] cur;
  logic [RATE_W-1:0]        pmag;
  logic [RATE_W-1:0]        mcand;
  logic [GAIN_W-1:0]        gain_sh;
  logic [RATE_W-1:0]        prod;
  logic [MUL_CNT_W-1:0]     mcnt;
  logic                     sum_neg;
  logic [RATE_W-1:0]        res;
  logic                     out_valid;
  logic [RATE_W-1:0]        out_data;

  logic              accept;
  logic              big;
  logic [RATE_W-1:0] in_cmag;
  logic [RATE_W-1:0] in_pmag;
  logic [3:0]        ax_ext;
  logic              ax_valid;
  logic [AIDX_W-1:0] idx;
  logic [SUM_W-1:0]  sum_sel;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic              rising;
  logic [CNT_W-1:0]  run_cur;
  logic              emit;
  logic              in_ready;
  logic              out_load;
  logic              div_start;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SAMPLE_COUNT_RST;
      drift_gain   <= DRIFT_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_COUNT: sample_count <= cfg_data[CNT_W-1:0];
        REG_DRIFT_GAIN:   drift_gain   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = in_ch.valid && in_ready;
  assign in_cmag = in_ch.sample[RATE_W-1] ? (~in_ch.sample + 1'b1) : in_ch.sample;
  assign in_pmag = in_ch.previous_sample[RATE_W-1] ? (~in_ch.previous_sample + 1'b1)
                                                   : in_ch.previous_sample;
  assign big     = in_cmag > HALF_DPS;

  // axis lookup, out-of-range axes read as zero and never write
  assign ax_ext   = {{(4 - AXIS_W){1'b0}}, ax};
  assign ax_valid = ax_ext < AXES_L;
  assign idx      = ax_ext[AIDX_W-1:0];
  assign sum_sel  = ax_valid ? axis_sum[idx] : '0;

  // |cur| <= 0.5 dps here, so its low 25 bits keep the sign
  assign sum_add = {sum_sel[SUM_W-1], sum_sel} + cur[SUM_W:0];
  assign sum_sat = (sum_add[SUM_W] != sum_add[SUM_W-1])
                   ? (sum_add[SUM_W] ? SUM_MIN : SUM_MAX)
                   : sum_add[SUM_W-1:0];

  assign rising  = {8'b0, prod} >= {pmag, 8'b0};
  assign run_cur = rising ? rising_run : falling_run;
  assign emit    = run_cur >= sample_count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = big ? ST_OUT : ST_MUL;
      ST_MUL:  if (mcnt == MUL_CNT_W'(MUL_STEPS - 1)) state_next = ST_CMP;
      ST_CMP:  state_next = emit ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_rsp.done) state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_CMP:  div_start = emit;
      ST_OUT:  out_load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  assign div_req = {div_start,
                    sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel,
                    (sample_count == '0) ? CNT_W'(1) : sample_count};

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // run counters and axis sums
  always_ff @(posedge clk) begin
    if (rst) begin
      rising_run  <= '0;
      falling_run <= '0;
      for (int i = 0; i < AXES; i++) axis_sum[i] <= '0;
    end else if (accept && big) begin
      rising_run  <= '0;
      falling_run <= '0;
    end else if (state == ST_CMP) begin
      if (rising) begin
        if (emit) begin
          rising_run <= '0;
        end else begin
          falling_run <= '0;
          rising_run  <= rising_run + 1'b1;
        end
      end else begin
        if (emit) begin
          falling_run <= '0;
        end else begin
          rising_run  <= '0;
          falling_run <= falling_run + 1'b1;
        end
      end
      if (ax_valid) axis_sum[idx] <= emit ? '0 : sum_sat;
    end
  end

  // sample capture, shift-add multiplier and result selection
  always_ff @(posedge clk) begin
    if (accept) begin
      ax      <= in_ch.axis;
      cur     <= in_ch.sample;
      pmag    <= in_pmag;
      mcand   <= {{(RATE_W - GAIN_W){1'b0}}, in_cmag[GAIN_W-1:0]};
      gain_sh <= drift_gain;
      prod    <= '0;
      mcnt    <= '0;
      res     <= in_ch.sample;
    end else begin
      case (state)
        ST_MUL: begin
          if (gain_sh[0]) prod <= prod + mcand;
          gain_sh <= gain_sh >> 1;
          mcand   <= mcand << 1;
          mcnt    <= mcnt + 1'b1;
        end
        ST_CMP: begin
          sum_neg <= sum_sel[SUM_W-1];
          if (!emit) res <= '0;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            res <= sum_neg ? (~{8'b0, div_rsp.quotient} + 1'b1)
                           : {8'b0, div_rsp.quotient};
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
  end

  gdda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.corrected_rate = out_data;

  `GDDA_ASSERT(a_one_run_active, clk, rst, !((rising_run != '0) && (falling_run != '0)), "both run counters nonzero")
  `GDDA_ASSERT(a_accept_moves_on, clk, rst, accept |=> (state == ST_MUL) || (state == ST_OUT), "accepted sample not processed")
  `GDDA_ASSERT(a_div_nonzero, clk, rst, div_req.start |-> (div_req.divisor != '0), "divider started with zero divisor")

endmodule
